// File: sv/mm64_pkg.sv
// ----------------------------------------------------------------------------
// mm64_pkg
// Shared widths and types for the 64-bit modular multiplier.
// ----------------------------------------------------------------------------
package mm64_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned ProdW = 128;
  localparam int unsigned RemW  = 65;
  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned RedStages    = ProdW / BitsPerStage;

  typedef struct packed {
    logic [WordW-1:0] modulus;
    logic             bad;
  } mm64_side_t;

  // One restoring-division step: shift in one bit, subtract the modulus when it fits.
  function automatic logic [WordW-1:0] red_step(input logic [WordW-1:0] r,
                                                input logic             b,
                                                input logic [WordW-1:0] m);
    logic [RemW-1:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[WordW-1:0];
  endfunction
endpackage

// File: sv/mm64_mul.sv
// ----------------------------------------------------------------------------
// mm64_mul
// Pipelined 64x64 multiplier: four 32x32 partial products, then summation.
// ----------------------------------------------------------------------------
module mm64_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [mm64_pkg::WordW-1:0]       a,
  input  logic [mm64_pkg::WordW-1:0]       b,
  input  mm64_pkg::mm64_side_t             in_side,
  output logic                             out_valid,
  output logic [mm64_pkg::ProdW-1:0]       prod,
  output mm64_pkg::mm64_side_t             out_side
);
  localparam int unsigned H = mm64_pkg::HalfW;

  logic [2*H-1:0] p00, p01, p10, p11;
  logic           v1;
  mm64_pkg::mm64_side_t s1;

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= a[H-1:0] * b[H-1:0];
      p01 <= a[H-1:0] * b[2*H-1:H];
      p10 <= a[2*H-1:H] * b[H-1:0];
      p11 <= a[2*H-1:H] * b[2*H-1:H];
      s1  <= in_side;
      prod <= {p11, p00} + ({{H{1'b0}}, p01, {H{1'b0}}})
                         + ({{H{1'b0}}, p10, {H{1'b0}}});
      out_side <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end
endmodule

// File: sv/mm64_red.sv
// ----------------------------------------------------------------------------
// mm64_red
// Pipelined restoring reduction of a 128-bit product, four bits a stage.
// ----------------------------------------------------------------------------
module mm64_red (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [mm64_pkg::ProdW-1:0]       prod,
  input  mm64_pkg::mm64_side_t             in_side,
  output logic                             out_valid,
  output logic [mm64_pkg::WordW-1:0]       rem,
  output logic                             bad
);
  localparam int unsigned N = mm64_pkg::RedStages;
  localparam int unsigned K = mm64_pkg::BitsPerStage;
  localparam int unsigned P = mm64_pkg::ProdW;
  localparam int unsigned W = mm64_pkg::WordW;

  logic [W-1:0]          r  [N];
  logic [P-1:0]          q  [N];
  mm64_pkg::mm64_side_t  sd [N];
  logic [N-1:0]          v;

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [W-1:0] r_in, r_next;
    logic [P-1:0] q_in;
    mm64_pkg::mm64_side_t sd_in;
    if (s == 0) begin : g_first
      assign r_in  = '0;
      assign q_in  = prod;
      assign sd_in = in_side;
    end else begin : g_rest
      assign r_in  = r[s-1];
      assign q_in  = q[s-1];
      assign sd_in = sd[s-1];
    end
    always_comb begin
      r_next = r_in;
      for (int i = 0; i < K; i++) begin
        r_next = mm64_pkg::red_step(r_next, q_in[P-1-i], sd_in.modulus);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r[s]  <= r_next;
        q[s]  <= {q_in[P-K-1:0], {K{1'b0}}};
        sd[s] <= sd_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-2:0], in_valid};
    end
  end

  assign out_valid = v[N-1];
  assign rem = sd[N-1].bad ? '0 : r[N-1];
  assign bad = sd[N-1].bad;
endmodule

// File: sv/modular_multiply_64.sv
// ----------------------------------------------------------------------------
// modular_multiply_64
// (a * b) mod m on 64-bit unsigned operands, exact over the 128-bit product.
// ----------------------------------------------------------------------------
// Pipeline: the multiply registers, the reduction stages and the output register,
// holding while the output is stalled.
// Throughput: one beat per cycle; the whole pipe advances when the output
// register is empty or being taken.
// Reset: rst clears all valid bits; data registers are not reset.
module modular_multiply_64 (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // multiplicand[63:0], multiplier[127:64], modulus[191:128]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // product_mod[63:0]
  output logic         m_tuser   // bad_modulus
);
  localparam int unsigned W = mm64_pkg::WordW;

  logic en;
  logic mv, rv, rbad;
  logic [mm64_pkg::ProdW-1:0] prod;
  logic [W-1:0] rrem;
  mm64_pkg::mm64_side_t side_in, side_m;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign side_in = {s_tdata[3*W-1:2*W], (s_tdata[3*W-1:2*W] == '0)};

  mm64_mul u_mul (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .a(s_tdata[W-1:0]), .b(s_tdata[2*W-1:W]), .in_side(side_in),
    .out_valid(mv), .prod(prod), .out_side(side_m)
  );

  mm64_red u_red (
    .clk(clk), .rst(rst), .en(en), .in_valid(mv), .prod(prod), .in_side(side_m),
    .out_valid(rv), .rem(rrem), .bad(rbad)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= rrem;
      m_tuser <= rbad;
    end
  end
endmodule

// File: sv/mm64_checker.sv
// ----------------------------------------------------------------------------
// mm64_checker
// Port-level checks for the modular multiplier.
// ----------------------------------------------------------------------------
module mm64_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0) else $error("bad modulus result not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled beat changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready)) else $error("ready not tied to output");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("valid after reset");
  logic unused;
  assign unused = s_tvalid;
endmodule

bind modular_multiply_64 mm64_checker u_chk (.*);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for modular_multiply_64: directed corner operands, a
// long output hold-off, then random beats with bursty input and output stalls.
// Every result is compared with a 128-bit product reduced in the bench.
// ----------------------------------------------------------------------------
module tb;
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         m_tuser;

  typedef struct {
    logic [63:0] rem;
    logic        bad;
  } mulmod_t;

  mulmod_t     exp_q[$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_bad = 0;
  int          cycles = 0;
  int          hold_off = 0;
  bit          rx_random = 1'b0;
  int          burst_left = 0;

  localparam int Limit = 400000;

  modular_multiply_64 dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic mulmod_t mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    mulmod_t      r;
    logic [127:0] p;
    if (m == 0) begin
      r.rem = '0;
      r.bad = 1'b1;
    end else begin
      p = {64'd0, a} * {64'd0, b};
      r.rem = 64'(p % {64'd0, m});
      r.bad = 1'b0;
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_got++;
      if (exp_q.size() == 0) begin
        $error("unexpected beat: product_mod %h bad_modulus %b", m_tdata, m_tuser);
        errors++;
      end else begin
        if (m_tdata !== exp_q[0].rem) begin
          $error("product_mod expected %h actual %h", exp_q[0].rem, m_tdata);
          errors++;
        end
        if (m_tuser !== exp_q[0].bad) begin
          $error("bad_modulus expected %b actual %b", exp_q[0].bad, m_tuser);
          errors++;
        end
        void'(exp_q.pop_front());
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (!rx_random) begin
      m_tready <= 1'b1;
    end else if (burst_left > 0) begin
      m_tready <= 1'b1;
      burst_left <= burst_left - 1;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 15) == 0) burst_left <= $urandom_range(10, 60);
    end
  end

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = v >> $urandom_range(1, 63);
      1: v = v | (64'hFFFF_FFFF_0000_0000 >> $urandom_range(0, 32));
      2: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      3: v = 64'($urandom_range(0, 3));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_beat(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    s_tdata  <= {m, b, a};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    exp_q.push_back(mulmod(a, b, m));
    if (m == 0) n_bad++;
    n_sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic test_corners();
    logic [63:0] mx;
    mx = '1;
    send_beat(64'd0, 64'd0, mx);
    send_beat(mx, mx, mx);
    send_beat(mx, mx, mx - 64'd1);
    send_beat(mx, mx, 64'd0);
    send_beat(64'd5, 64'd7, 64'd0);
    send_beat(mx, 64'd12345, 64'd1);
    send_beat(mx, mx, 64'd1);
    send_beat(mx, mx, 64'd2);
    send_beat(64'h1_0000_0000, 64'h1_0000_0000, 64'h1_0000_0001);
    send_beat(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
    send_beat(64'h8000_0000_0000_0000, 64'd2, 64'h8000_0000_0000_0001);
    send_beat(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_beat(64'hDEAD_BEEF_CAFE_F00D, 64'h0123_4567_89AB_CDEF, 64'h7FFF_FFFF_FFFF_FFE7);
    send_beat(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'h1_0000_0003);
    send_beat(64'd3, 64'd4, 64'd5);
    idle_sender(1);
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    repeat (120) send_beat(rand64(), rand64(), rand64());
    idle_sender(1);
  endtask

  task automatic test_random(int n);
    int k;
    rx_random = 1'b1;
    k = 0;
    while (k < n) begin
      repeat ($urandom_range(1, 40)) begin
        if (k < n) begin
          send_beat(rand64(), rand64(), ($urandom_range(0, 30) == 0) ? 64'd0 : rand64());
          k++;
        end
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
    idle_sender(1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corners();
    test_backpressure();
    test_random(1400);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d beats (%0d with zero modulus), checked %0d results.",
             n_sent, n_bad, n_got);
    $display("Covered corner operands, a long output hold-off and random stalls.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
